[src/wsmp_frame_parser_macros.svh]
// Assertion helpers. Each expects clk and arst_n in the enclosing module.
`ifndef WSMP_FRAME_PARSER_MACROS_SVH
`define WSMP_FRAME_PARSER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define WSMP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WSMP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define WSMP_ASSERT_NOW(label, ante, cons, msg)
`define WSMP_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[src/wsmp_fp_pkg.sv]
package wsmp_fp_pkg;

	localparam int ID_W         = 28;
	localparam int FIFO_DEPTH   = 2;
	localparam logic [3:0] VERSION_RESET = 4'd3;

	typedef enum logic [2:0] {
		PH_VERSION  = 3'd0,
		PH_ID_FIRST = 3'd1,
		PH_ID_MORE  = 3'd2,
		PH_LENGTH   = 3'd3,
		PH_PAYLOAD  = 3'd4,
		PH_SKIP     = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_VERSION = 2'd1,
		ST_BAD_PREFIX  = 2'd2,
		ST_TRUNCATED   = 2'd3
	} status_t;

	typedef struct packed {
		logic            payload_valid;
		logic [7:0]      payload_byte;
		logic            frame_done;
		status_t         status;
		logic [ID_W-1:0] service_id;
		logic [7:0]      payload_length;
	} result_t;

endpackage

[src/wsmp_fp_if.sv]
interface wsmp_fp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface wsmp_fp_result_if;
	logic                        valid;
	logic                        ready;
	logic                        payload_valid;
	logic [7:0]                  payload_byte;
	logic                        frame_done;
	logic [1:0]                  status;
	logic [wsmp_fp_pkg::ID_W-1:0] service_id;
	logic [7:0]                  payload_length;

	modport source (output valid, output payload_valid, output payload_byte,
		output frame_done, output status, output service_id, output payload_length,
		input ready);
	modport sink   (input valid, input payload_valid, input payload_byte,
		input frame_done, input status, input service_id, input payload_length,
		output ready);
endinterface

[src/wsmp_frame_parser.sv]
// channel   dir  payload                                              items
// frame     in   data_byte, frame_end                                 1 per byte
// result    out  payload_valid/byte, frame_done, status,              1 per byte
//                service_id, payload_length
//
// One byte per cycle while the queue has room; each byte yields one result item.
// The parser updates its header state in the cycle the byte is accepted.
// arst_n clears parser state, queue pointers and the output valid; version resets to 3.
// frame.ready drops only when the result queue is full (result side stalled).
module wsmp_frame_parser #(
	parameter int FIFO_DEPTH = wsmp_fp_pkg::FIFO_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	wsmp_fp_byte_if.sink       frame,
	wsmp_fp_result_if.source   result
);

	logic                 accept;
	logic                 q_full, q_empty, q_pop;
	wsmp_fp_pkg::result_t front_res, q_head;

	assign frame.ready = !q_full;
	assign accept      = frame.valid && !q_full;

	wsmp_fp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.data_byte (frame.data_byte),
		.frame_end (frame.frame_end),
		.result    (front_res)
	);

	wsmp_fp_queue #(
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (front_res),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	wsmp_fp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

[src/wsmp_fp_front.sv]
`include "wsmp_frame_parser_macros.svh"

// Header parser: one byte per accepted item, one result per byte.
module wsmp_fp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_wdata,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 frame_end,
	output wsmp_fp_pkg::result_t result
);

	localparam int IdW = wsmp_fp_pkg::ID_W;

	logic [3:0]            version_q;
	wsmp_fp_pkg::phase_t   phase_q, phase_d;
	logic [IdW-1:0]        acc_q, acc_d;
	logic [1:0]            id_left_q, id_left_d;
	logic [7:0]            len_q, len_d;
	logic [7:0]            pay_left_q, pay_left_d;
	logic                  decided_q, decided_d;
	logic                  done;
	wsmp_fp_pkg::status_t  st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= wsmp_fp_pkg::VERSION_RESET;
		end else if (cfg_we) begin
			version_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsmp_fp_pkg::PH_VERSION;
			acc_q      <= '0;
			id_left_q  <= '0;
			len_q      <= '0;
			pay_left_q <= '0;
			decided_q  <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			acc_q      <= acc_d;
			id_left_q  <= id_left_d;
			len_q      <= len_d;
			pay_left_q <= pay_left_d;
			decided_q  <= decided_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		id_left_d  = id_left_q;
		len_d      = len_q;
		pay_left_d = pay_left_q;
		decided_d  = decided_q;
		done       = 1'b0;
		st         = wsmp_fp_pkg::ST_OK;
		result     = '0;

		unique case (phase_q)
			wsmp_fp_pkg::PH_VERSION: begin
				if (data_byte[3:0] != version_q) begin
					done = 1'b1;
					st   = wsmp_fp_pkg::ST_BAD_VERSION;
				end else begin
					phase_d = wsmp_fp_pkg::PH_ID_FIRST;
				end
			end
			wsmp_fp_pkg::PH_ID_FIRST: begin
				// leading ones give the count of extra id bytes
				if (!data_byte[7]) begin
					acc_d     = {{(IdW-8){1'b0}}, data_byte};
					id_left_d = 2'd0;
					phase_d   = wsmp_fp_pkg::PH_LENGTH;
				end else if (data_byte[7:6] == 2'b10) begin
					acc_d     = {{(IdW-6){1'b0}}, data_byte[5:0]};
					id_left_d = 2'd1;
					phase_d   = wsmp_fp_pkg::PH_ID_MORE;
				end else if (data_byte[7:5] == 3'b110) begin
					acc_d     = {{(IdW-5){1'b0}}, data_byte[4:0]};
					id_left_d = 2'd2;
					phase_d   = wsmp_fp_pkg::PH_ID_MORE;
				end else if (data_byte[7:4] == 4'b1110) begin
					acc_d     = {{(IdW-4){1'b0}}, data_byte[3:0]};
					id_left_d = 2'd3;
					phase_d   = wsmp_fp_pkg::PH_ID_MORE;
				end else begin
					done = 1'b1;
					st   = wsmp_fp_pkg::ST_BAD_PREFIX;
				end
			end
			wsmp_fp_pkg::PH_ID_MORE: begin
				acc_d     = {acc_q[IdW-9:0], data_byte};
				id_left_d = id_left_q - 2'd1;
				if (id_left_d == 2'd0) begin
					phase_d = wsmp_fp_pkg::PH_LENGTH;
				end
			end
			wsmp_fp_pkg::PH_LENGTH: begin
				len_d      = data_byte;
				pay_left_d = data_byte;
				if (data_byte == 8'd0) begin
					done = 1'b1;
				end else begin
					phase_d = wsmp_fp_pkg::PH_PAYLOAD;
				end
			end
			wsmp_fp_pkg::PH_PAYLOAD: begin
				result.payload_valid = 1'b1;
				result.payload_byte  = data_byte;
				pay_left_d           = pay_left_q - 8'd1;
				if (pay_left_d == 8'd0) begin
					done = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (done) begin
			decided_d             = 1'b1;
			phase_d               = wsmp_fp_pkg::PH_SKIP;
			result.frame_done     = 1'b1;
			result.status         = st;
			result.service_id     = (st == wsmp_fp_pkg::ST_OK) ? acc_d : '0;
			result.payload_length = len_d;
		end else if (frame_end && !decided_q) begin
			result.frame_done     = 1'b1;
			result.status         = wsmp_fp_pkg::ST_TRUNCATED;
			result.payload_length = len_d;
		end

		if (frame_end) begin
			phase_d    = wsmp_fp_pkg::PH_VERSION;
			acc_d      = '0;
			id_left_d  = '0;
			len_d      = '0;
			pay_left_d = '0;
			decided_d  = 1'b0;
		end
	end

	`WSMP_ASSERT_NXT(a_end_clears, accept && frame_end,
		phase_q == wsmp_fp_pkg::PH_VERSION && !decided_q, "frame end did not clear state")
	`WSMP_ASSERT_NXT(a_ok_payload_drained,
		accept && !frame_end && result.frame_done && result.status == wsmp_fp_pkg::ST_OK,
		pay_left_q == 8'd0 && phase_q == wsmp_fp_pkg::PH_SKIP, "accepted frame left payload due")

endmodule

[src/wsmp_fp_queue.sv]
`include "wsmp_frame_parser_macros.svh"

// Small queue of classified results between parser and output stage.
module wsmp_fp_queue #(
	parameter int DEPTH = wsmp_fp_pkg::FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wsmp_fp_pkg::result_t push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output wsmp_fp_pkg::result_t head
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

	wsmp_fp_pkg::result_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == DepthCnt);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`WSMP_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into full queue")
	`WSMP_ASSERT_NOW(a_no_underflow, pop, !empty, "pop from empty queue")
	`WSMP_ASSERT_NXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1,
		"queue count did not advance")

endmodule

[src/wsmp_fp_back.sv]
// Output register: takes the queue head whenever the register is free or drains.
module wsmp_fp_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  wsmp_fp_pkg::result_t     q_head,
	output logic                     q_pop,
	wsmp_fp_result_if.source         result
);

	logic                 valid_q;
	wsmp_fp_pkg::result_t data_q;

	assign q_pop = !q_empty && (!valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || result.ready) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= q_head;
		end
	end

	assign result.valid          = valid_q;
	assign result.payload_valid  = data_q.payload_valid;
	assign result.payload_byte   = data_q.payload_byte;
	assign result.frame_done     = data_q.frame_done;
	assign result.status         = data_q.status;
	assign result.service_id     = data_q.service_id;
	assign result.payload_length = data_q.payload_length;

endmodule

[tb/tb_wsmp_frame_parser.sv]
module tb_wsmp_frame_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES = 1500;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_IDLE     = 11;
	localparam int IdW          = wsmp_fp_pkg::ID_W;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_wdata;

	wsmp_fp_byte_if   frame_bus ();
	wsmp_fp_result_if result_bus ();

	wsmp_frame_parser DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.frame     (frame_bus),
		.result    (result_bus)
	);

	// parser shadow state
	logic [3:0]          exp_version;
	wsmp_fp_pkg::phase_t exp_phase;
	logic [IdW-1:0]      exp_id;
	logic [1:0]          exp_id_left;
	logic [7:0]          exp_len;
	logic [7:0]          exp_pay_left;
	logic                exp_decided;

	wsmp_fp_pkg::result_t pending_results[$];
	logic [7:0]           frame_buf[$];

	bit src_idle;
	bit snk_idle;
	int err_count;
	int bytes_sent;
	int frames_sent;
	int results_checked;
	int payload_seen;
	int status_seen[4];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout: %0d results still outstanding", pending_results.size());
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic void clear_frame_state();
		exp_phase    = wsmp_fp_pkg::PH_VERSION;
		exp_id       = '0;
		exp_id_left  = '0;
		exp_len      = '0;
		exp_pay_left = '0;
		exp_decided  = 1'b0;
	endfunction

	// advance the shadow parser by one byte and queue the result it causes
	function automatic void predict_parse_result(input logic [7:0] b, input logic fend);
		wsmp_fp_pkg::result_t r;
		logic                 done;
		wsmp_fp_pkg::status_t st;
		r    = '0;
		done = 1'b0;
		st   = wsmp_fp_pkg::ST_OK;
		case (exp_phase)
			wsmp_fp_pkg::PH_VERSION: begin
				if (b[3:0] != exp_version) begin
					done = 1'b1;
					st   = wsmp_fp_pkg::ST_BAD_VERSION;
				end else begin
					exp_phase = wsmp_fp_pkg::PH_ID_FIRST;
				end
			end
			wsmp_fp_pkg::PH_ID_FIRST: begin
				if (!b[7]) begin
					exp_id      = IdW'(b);
					exp_id_left = 2'd0;
					exp_phase   = wsmp_fp_pkg::PH_LENGTH;
				end else if (b[7:6] == 2'b10) begin
					exp_id      = IdW'(b[5:0]);
					exp_id_left = 2'd1;
					exp_phase   = wsmp_fp_pkg::PH_ID_MORE;
				end else if (b[7:5] == 3'b110) begin
					exp_id      = IdW'(b[4:0]);
					exp_id_left = 2'd2;
					exp_phase   = wsmp_fp_pkg::PH_ID_MORE;
				end else if (b[7:4] == 4'b1110) begin
					exp_id      = IdW'(b[3:0]);
					exp_id_left = 2'd3;
					exp_phase   = wsmp_fp_pkg::PH_ID_MORE;
				end else begin
					done = 1'b1;
					st   = wsmp_fp_pkg::ST_BAD_PREFIX;
				end
			end
			wsmp_fp_pkg::PH_ID_MORE: begin
				exp_id      = {exp_id[IdW-9:0], b};
				exp_id_left = exp_id_left - 2'd1;
				if (exp_id_left == 2'd0)
					exp_phase = wsmp_fp_pkg::PH_LENGTH;
			end
			wsmp_fp_pkg::PH_LENGTH: begin
				exp_len      = b;
				exp_pay_left = b;
				if (b == 8'd0)
					done = 1'b1;
				else
					exp_phase = wsmp_fp_pkg::PH_PAYLOAD;
			end
			wsmp_fp_pkg::PH_PAYLOAD: begin
				r.payload_valid = 1'b1;
				r.payload_byte  = b;
				exp_pay_left    = exp_pay_left - 8'd1;
				if (exp_pay_left == 8'd0)
					done = 1'b1;
			end
			default: ;
		endcase
		if (done) begin
			exp_decided      = 1'b1;
			exp_phase        = wsmp_fp_pkg::PH_SKIP;
			r.frame_done     = 1'b1;
			r.status         = st;
			r.service_id     = (st == wsmp_fp_pkg::ST_OK) ? exp_id : '0;
			r.payload_length = exp_len;
		end else if (fend && !exp_decided) begin
			r.frame_done     = 1'b1;
			r.status         = wsmp_fp_pkg::ST_TRUNCATED;
			r.payload_length = exp_len;
		end
		if (fend)
			clear_frame_state();
		pending_results.push_back(r);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic fend);
		int gap;
		gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			frame_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_bus.valid     = 1'b1;
		frame_bus.data_byte = b;
		frame_bus.frame_end = fend;
		do @(posedge clk); while (!frame_bus.ready);
		predict_parse_result(b, fend);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	task automatic drain_results();
		frame_bus.valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_version(input logic [3:0] v);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we      = 1'b0;
		exp_version = v;
	endtask

	// well-formed frame: version, P-encoded id of id_len bytes, length, payload, trailer
	function automatic void build_frame(input int id_len, input int plen, input int trail);
		logic [31:0] r;
		frame_buf.delete();
		r = $urandom();
		frame_buf.push_back({r[7:4], exp_version});
		r = $urandom();
		case (id_len)
			1:       frame_buf.push_back({1'b0, r[6:0]});
			2:       frame_buf.push_back({2'b10, r[5:0]});
			3:       frame_buf.push_back({3'b110, r[4:0]});
			default: frame_buf.push_back({4'b1110, r[3:0]});
		endcase
		for (int i = 1; i < id_len; i++)
			frame_buf.push_back(8'($urandom()));
		frame_buf.push_back(8'(plen));
		for (int i = 0; i < plen + trail; i++)
			frame_buf.push_back(8'($urandom()));
	endfunction

	task automatic test_directed_cases();
		src_idle = 1'b1;
		snk_idle = 1'b1;
		// smallest good frame, zero-length payload
		frame_buf = '{8'h03, 8'h00, 8'h00};
		send_frame();
		// bad version on a one-byte frame
		frame_buf = '{8'hF4};
		send_frame();
		// good version, then the frame ends
		frame_buf = '{8'h03};
		send_frame();
		// illegal id prefix, rest skipped
		frame_buf = '{8'h13, 8'hFF, 8'hAA};
		send_frame();
		// largest 4-byte id
		frame_buf = '{8'h03, 8'hEF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF};
		send_frame();
		// ends on a payload byte that is still passed through
		frame_buf = '{8'h03, 8'h7F, 8'h02, 8'h11};
		send_frame();
		// 3-byte id, trailing bytes ignored
		frame_buf = '{8'h03, 8'hC0, 8'h00, 8'h00, 8'h01, 8'h55, 8'h99};
		send_frame();
	endtask

	task automatic test_version_register();
		logic [3:0] vers[3];
		vers = '{4'd0, 4'd15, 4'd9};
		foreach (vers[k]) begin
			drain_results();
			set_version(vers[k]);
			build_frame(2, 3, 1);
			send_frame();
			build_frame(1, 0, 0);
			frame_buf[0][3:0] = ~vers[k];
			send_frame();
		end
	endtask

	task automatic test_random_traffic();
		int target;
		int kind;
		int plen;
		int cut;
		int n;
		target = bytes_sent + RANDOM_BYTES;
		n = 0;
		while (bytes_sent < target) begin
			// pause until everything is out, then move the version
			if (n % 40 == 39) begin
				drain_results();
				set_version(4'($urandom_range(0, 15)));
			end
			n++;
			src_idle = $urandom_range(0, 3) != 0;
			snk_idle = $urandom_range(0, 3) != 0;
			plen = ($urandom_range(0, 99) < 2) ? $urandom_range(0, 255) : $urandom_range(0, 12);
			build_frame($urandom_range(1, 4), plen,
				($urandom_range(0, 1) != 0) ? $urandom_range(1, 3) : 0);
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
			end else if (kind < 82) begin
				cut = $urandom_range(1, frame_buf.size() - 1);
				while (frame_buf.size() > cut) void'(frame_buf.pop_back());
			end else if (kind < 88) begin
				frame_buf[0][3:0] = exp_version + 4'($urandom_range(1, 15));
			end else if (kind < 94) begin
				frame_buf[1] = {4'hF, 4'($urandom())};
			end else begin
				frame_buf.delete();
				repeat ($urandom_range(1, 6)) frame_buf.push_back(8'($urandom()));
			end
			send_frame();
		end
		frame_bus.valid = 1'b0;
	endtask

	initial begin : result_checker
		int                   stall;
		wsmp_fp_pkg::result_t want;
		stall = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result item with nothing expected");
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					if (want.payload_valid)
						payload_seen++;
					if (want.frame_done)
						status_seen[want.status]++;
					if (result_bus.payload_valid !== want.payload_valid)
						report_mismatch($sformatf("payload_valid %b, want %b",
							result_bus.payload_valid, want.payload_valid));
					if (result_bus.payload_byte !== want.payload_byte)
						report_mismatch($sformatf("payload_byte %h, want %h",
							result_bus.payload_byte, want.payload_byte));
					if (result_bus.frame_done !== want.frame_done)
						report_mismatch($sformatf("frame_done %b, want %b",
							result_bus.frame_done, want.frame_done));
					if (result_bus.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							result_bus.status, want.status));
					if (result_bus.service_id !== want.service_id)
						report_mismatch($sformatf("service_id %h, want %h",
							result_bus.service_id, want.service_id));
					if (result_bus.payload_length !== want.payload_length)
						report_mismatch($sformatf("payload_length %0d, want %0d",
							result_bus.payload_length, want.payload_length));
				end
				stall = snk_idle ? $urandom_range(0, MAX_IDLE) : 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				result_bus.ready = 1'b0;
				stall--;
			end else begin
				result_bus.ready = 1'b1;
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		frame_bus.valid     = 1'b0;
		frame_bus.data_byte = '0;
		frame_bus.frame_end = 1'b0;
		src_idle            = 1'b0;
		snk_idle            = 1'b0;
		exp_version         = wsmp_fp_pkg::VERSION_RESET;
		clear_frame_state();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_version_register();
		test_random_traffic();

		while (pending_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("sent %0d bytes in %0d frames, checked %0d results, %0d payload bytes",
			bytes_sent, frames_sent, results_checked, payload_seen);
		$display("outcomes: ok %0d, bad version %0d, bad prefix %0d, truncated %0d; errors %0d",
			status_seen[wsmp_fp_pkg::ST_OK], status_seen[wsmp_fp_pkg::ST_BAD_VERSION],
			status_seen[wsmp_fp_pkg::ST_BAD_PREFIX], status_seen[wsmp_fp_pkg::ST_TRUNCATED],
			err_count);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/wsmp_fp_pkg.sv
src/wsmp_fp_if.sv
src/wsmp_fp_front.sv
src/wsmp_fp_queue.sv
src/wsmp_fp_back.sv
src/wsmp_frame_parser.sv
tb/tb_wsmp_frame_parser.sv
